FILE: sv/jsu_pkg.sv
// Package with the shared types, character codes and helpers of the JSON string unescaper.
package jsu_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_ESCAPE  = 2'd1,
        MODE_UNICODE = 2'd2
    } parse_mode_t;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_U   = 8'h75;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;

    localparam logic [15:0] UTF8_MAX_ONE = 16'h007F;
    localparam logic [15:0] UTF8_MAX_TWO = 16'h07FF;
    localparam logic [7:0]  UTF8_LEAD2   = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3   = 8'hE0;
    localparam logic [7:0]  UTF8_CONT    = 8'h80;
    localparam logic [5:0]  UTF8_MASK6   = 6'h3F;

    localparam logic [1:0] LAST_HEX_BYTE = 2'd3;

    typedef struct packed {
        parse_mode_t mode;
        logic [1:0]  hex_count;
        logic [15:0] code_accum;
        logic        prefix_ended;
        logic        digit_seen;
    } parse_state_t;

    // All results caused by one input byte; count is zero when it causes none.
    typedef struct packed {
        logic [1:0]      count;
        logic            byte_valid;
        logic            string_end;
        logic            bad_escape;
        logic [2:0][7:0] bytes;
    } result_group_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t h;
        h.ok    = 1'b0;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.ok    = 1'b1;
            h.value = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            h.ok    = 1'b1;
            h.value = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            h.ok    = 1'b1;
            h.value = 4'(c - 8'h37);
        end
        return h;
    endfunction

endpackage

FILE: sv/jsu_if.sv
// Stream interfaces for the raw string bytes and for the decoded results.
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_end;
    logic       bad_escape;
    logic       last;

    modport source (output valid, output out_byte, output byte_valid, output string_end,
                    output bad_escape, output last, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input string_end,
                    input bad_escape, input last, output ready);
endinterface

FILE: sv/jsu_decode.sv
// Combinational escape parser: next parser state and the result group for one byte.
module jsu_decode
    import jsu_pkg::*;
(
    input  parse_state_t  state,
    input  logic [7:0]    in_byte,
    output parse_state_t  state_next,
    output result_group_t group
);

    hex_digit_t  hex;
    parse_state_t upd;
    logic [15:0] cp;

    always_comb
    begin
        hex        = hex_decode(in_byte);
        upd        = state;
        cp         = 16'd0;
        state_next = state;
        group      = '0;

        unique case (state.mode)
            MODE_ESCAPE:
            begin
                if (in_byte == CH_LOWER_U)
                begin
                    state_next = '0;
                    state_next.mode = MODE_UNICODE;
                end
                else
                begin
                    state_next.mode     = MODE_NORMAL;
                    group.count         = 2'd1;
                    group.byte_valid    = 1'b1;
                    case (in_byte)
                        CH_LOWER_N: group.bytes[0] = CH_LF;
                        CH_LOWER_R: group.bytes[0] = CH_CR;
                        CH_LOWER_T: group.bytes[0] = CH_TAB;
                        default:    group.bytes[0] = in_byte;
                    endcase
                end
            end

            MODE_UNICODE:
            begin
                // Hex digits count only until the first non-hex byte.
                if (!state.prefix_ended && hex.ok)
                begin
                    upd.code_accum = {state.code_accum[11:0], hex.value};
                    upd.digit_seen = 1'b1;
                end
                else
                begin
                    upd.prefix_ended = 1'b1;
                end

                if (state.hex_count != LAST_HEX_BYTE)
                begin
                    state_next           = upd;
                    state_next.hex_count = state.hex_count + 2'd1;
                end
                else
                begin
                    state_next = '0;
                    cp         = upd.code_accum;
                    if (!upd.digit_seen)
                    begin
                        group.count      = 2'd1;
                        group.bad_escape = 1'b1;
                    end
                    else if (cp <= UTF8_MAX_ONE)
                    begin
                        group.count      = 2'd1;
                        group.byte_valid = 1'b1;
                        group.bytes[0]   = cp[7:0];
                    end
                    else if (cp <= UTF8_MAX_TWO)
                    begin
                        group.count      = 2'd2;
                        group.byte_valid = 1'b1;
                        group.bytes[0]   = UTF8_LEAD2 | {3'd0, cp[10:6]};
                        group.bytes[1]   = UTF8_CONT | {2'd0, cp[5:0] & UTF8_MASK6};
                    end
                    else
                    begin
                        group.count      = 2'd3;
                        group.byte_valid = 1'b1;
                        group.bytes[0]   = UTF8_LEAD3 | {4'd0, cp[15:12]};
                        group.bytes[1]   = UTF8_CONT | {2'd0, cp[11:6] & UTF8_MASK6};
                        group.bytes[2]   = UTF8_CONT | {2'd0, cp[5:0] & UTF8_MASK6};
                    end
                end
            end

            default:
            begin
                state_next.mode = MODE_NORMAL;
                if (in_byte == CH_BACKSLASH)
                begin
                    state_next.mode = MODE_ESCAPE;
                end
                else if (in_byte == CH_QUOTE)
                begin
                    group.count      = 2'd1;
                    group.string_end = 1'b1;
                end
                else
                begin
                    group.count      = 2'd1;
                    group.byte_valid = 1'b1;
                    group.bytes[0]   = in_byte;
                end
            end
        endcase
    end

endmodule

FILE: sv/json_string_unescape_utf8_core.sv
// JSON string body unescaper: registered input byte, escape parser and UTF-8 result sequencer.
// Takes one string-body byte per transaction and returns its decoded results, one per cycle
// while the output is ready, with last marking the final result of each byte. A byte passes
// from the input register through the parser into the result register, and a new byte can
// be taken every cycle while the input side does not wait. The result register sends its group
// one result per cycle while the output is ready: a \u escape that encodes to two or three
// UTF-8 bytes occupies the output until all of them are sent. The input side waits when the
// byte in the input register causes a result while the result register still holds a group
// that is not done, either because the output is stalled or because a multi-byte group is
// still being sent. Bytes that cause no result (a backslash, the u of a \u escape and the
// first three bytes after it) never wait for the output.
module json_string_unescape_utf8_core
    import jsu_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    jsu_in_if.sink         raw,
    jsu_out_if.source      decoded
);

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    parse_state_t  state_reg;
    parse_state_t  state_next;
    result_group_t dec_group;
    logic          grp_valid_reg;
    result_group_t grp_reg;
    logic [1:0]    idx_reg;

    logic in_fire;
    logic out_fire;
    logic out_last;
    logic grp_free;
    logic consume;

    jsu_decode u_decode
    (
        .state      (state_reg),
        .in_byte    (in_byte_reg),
        .state_next (state_next),
        .group      (dec_group)
    );

    assign out_last = (idx_reg == grp_reg.count - 2'd1);
    assign out_fire = decoded.valid && decoded.ready;
    assign grp_free = !grp_valid_reg || (out_fire && out_last);
    assign consume  = in_valid_reg && ((dec_group.count == 2'd0) || grp_free);
    assign raw.ready = !in_valid_reg || consume;
    assign in_fire  = raw.valid && raw.ready;

    assign decoded.valid      = grp_valid_reg;
    assign decoded.out_byte   = grp_reg.bytes[idx_reg];
    assign decoded.byte_valid = grp_reg.byte_valid;
    assign decoded.string_end = grp_reg.string_end;
    assign decoded.bad_escape = grp_reg.bad_escape;
    assign decoded.last       = out_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= '0;
            grp_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            if (in_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (consume)
            begin
                in_valid_reg <= 1'b0;
            end

            if (consume)
            begin
                state_reg <= state_next;
            end

            if (consume && dec_group.count != 2'd0)
            begin
                grp_valid_reg <= 1'b1;
                idx_reg       <= 2'd0;
            end
            else if (out_fire)
            begin
                if (out_last)
                begin
                    grp_valid_reg <= 1'b0;
                    idx_reg       <= 2'd0;
                end
                else
                begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_byte_reg <= raw.in_byte;
        end
        if (consume && dec_group.count != 2'd0)
        begin
            grp_reg <= dec_group;
        end
    end

    // A held group always has a result left to send.
    a_group_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        grp_valid_reg |-> (grp_reg.count != 2'd0) && (idx_reg < grp_reg.count))
        else $error("result group held with no result left");

    // A result that is not the last of its group is followed by the next one.
    a_beat_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !out_last) |=> grp_valid_reg && (idx_reg == $past(idx_reg) + 2'd1))
        else $error("result sequence did not advance");

    // End-of-string and bad-escape results stand alone and carry no byte.
    a_flag_single: assert property (@(posedge clk) disable iff (!rst_n)
        (decoded.valid && (decoded.string_end || decoded.bad_escape))
            |-> decoded.last && !decoded.byte_valid)
        else $error("flag result not a single result");

    // The parser never steps while a group it would replace is still being sent.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && dec_group.count != 2'd0) |-> grp_free)
        else $error("result group overwritten");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the JSON string unescaper with UTF-8 output of unicode escapes.
module tb;
    import jsu_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_end;
        logic       bad_escape;
        logic       last;
    } unescaped_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        unescaped_t want;
    } script_row_t;

    localparam unescaped_t UNTYPED = '0;

    logic clk = 1'b0;
    logic rst_n;

    jsu_in_if  raw_if ();
    jsu_out_if dec_if ();

    json_string_unescape_utf8_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .raw     (raw_if.sink),
        .decoded (dec_if.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Decoder state as the block should hold it.
    parse_mode_t esc_mode;
    logic [1:0]  hex_seen;
    logic [15:0] code_pt;
    logic        prefix_done;
    logic        got_digit;

    unescaped_t  decoded_owed[$];
    unescaped_t  head;
    script_row_t script [0:24];

    int src_idle_pct;
    int snk_idle_pct;
    int mismatches;
    int bytes_sent;
    int results_seen;
    int ends_seen;
    int bad_seen;
    int multi_seen;

    function automatic logic is_hex_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
            return 8'h30 + {4'd0, v};
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'd0, v} - 8'd10;
    endfunction

    task automatic owe(input logic [7:0] b, input logic bv, input logic se, input logic be,
                       input logic fin);
        unescaped_t r;
        r.out_byte   = b;
        r.byte_valid = bv;
        r.string_end = se;
        r.bad_escape = be;
        r.last       = fin;
        decoded_owed.insert(decoded_owed.size(), r);
    endtask

    // Advances the decoder state by one accepted byte and queues what it yields.
    task automatic unescape_byte(input logic [7:0] c);
        logic [7:0]  b;
        logic [15:0] cp;
        logic        had_digit;
        case (esc_mode)
            MODE_ESCAPE:
            begin
                if (c == CH_LOWER_U)
                begin
                    esc_mode    = MODE_UNICODE;
                    hex_seen    = 2'd0;
                    code_pt     = 16'd0;
                    prefix_done = 1'b0;
                    got_digit   = 1'b0;
                end
                else
                begin
                    b = c;
                    if (c == CH_LOWER_N)
                        b = CH_LF;
                    else if (c == CH_LOWER_R)
                        b = CH_CR;
                    else if (c == CH_LOWER_T)
                        b = CH_TAB;
                    esc_mode = MODE_NORMAL;
                    owe(b, 1'b1, 1'b0, 1'b0, 1'b1);
                end
            end
            MODE_UNICODE:
            begin
                // Letters sit at 0x41/0x61 upward, so their low nibble plus nine is the value.
                if (!prefix_done && is_hex_char(c))
                begin
                    code_pt   = {code_pt[11:0], c[6] ? c[3:0] + 4'd9 : c[3:0]};
                    got_digit = 1'b1;
                end
                else
                    prefix_done = 1'b1;
                if (hex_seen != LAST_HEX_BYTE)
                    hex_seen = hex_seen + 2'd1;
                else
                begin
                    cp          = code_pt;
                    had_digit   = got_digit;
                    esc_mode    = MODE_NORMAL;
                    hex_seen    = 2'd0;
                    code_pt     = 16'd0;
                    prefix_done = 1'b0;
                    got_digit   = 1'b0;
                    if (!had_digit)
                        owe(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
                    else if (cp <= UTF8_MAX_ONE)
                        owe(cp[7:0], 1'b1, 1'b0, 1'b0, 1'b1);
                    else if (cp <= UTF8_MAX_TWO)
                    begin
                        owe({3'b110, cp[10:6]}, 1'b1, 1'b0, 1'b0, 1'b0);
                        owe({2'b10, cp[5:0]}, 1'b1, 1'b0, 1'b0, 1'b1);
                    end
                    else
                    begin
                        owe({4'b1110, cp[15:12]}, 1'b1, 1'b0, 1'b0, 1'b0);
                        owe({2'b10, cp[11:6]}, 1'b1, 1'b0, 1'b0, 1'b0);
                        owe({2'b10, cp[5:0]}, 1'b1, 1'b0, 1'b0, 1'b1);
                    end
                end
            end
            default:
            begin
                esc_mode = MODE_NORMAL;
                if (c == CH_BACKSLASH)
                    esc_mode = MODE_ESCAPE;
                else if (c == CH_QUOTE)
                    owe(8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
                else
                    owe(c, 1'b1, 1'b0, 1'b0, 1'b1);
            end
        endcase
    endtask

    // Called just after a rising edge; returns just after the edge that took the byte.
    task automatic push_raw(input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            raw_if.valid <= 1'b0;
            @(posedge clk);
        end
        raw_if.valid   <= 1'b1;
        raw_if.in_byte <= b;
        do
            @(negedge clk);
        while (!raw_if.ready);
        @(posedge clk);
        unescape_byte(b);
        bytes_sent++;
    endtask

    task automatic drain();
        raw_if.valid <= 1'b0;
        while (decoded_owed.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_token();
        int         pick;
        int         k;
        int         j;
        logic [7:0] b;
        logic [15:0] cp;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            do
                b = 8'($urandom_range(8'h20, 8'h7E));
            while (b == CH_BACKSLASH || b == CH_QUOTE);
            push_raw(b);
        end
        else if (pick < 35)
            push_raw(8'($urandom_range(0, 255)));
        else if (pick < 55)
        begin
            push_raw(CH_BACKSLASH);
            case ($urandom_range(0, 6))
                0: b = CH_QUOTE;
                1: b = CH_BACKSLASH;
                2: b = "/";
                3: b = CH_LOWER_N;
                4: b = CH_LOWER_R;
                5: b = CH_LOWER_T;
                default:
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == CH_LOWER_U)
                        b = CH_LOWER_N;
                end
            endcase
            push_raw(b);
        end
        else if (pick < 85)
        begin
            case ($urandom_range(0, 2))
                0: cp = 16'($urandom_range(16'h0000, 16'h007F));
                1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
            endcase
            push_raw(CH_BACKSLASH);
            push_raw(CH_LOWER_U);
            push_raw(hex_char(cp[15:12]));
            push_raw(hex_char(cp[11:8]));
            push_raw(hex_char(cp[7:4]));
            push_raw(hex_char(cp[3:0]));
        end
        else if (pick < 93)
        begin
            // Short hex prefix, then a terminating non-hex byte (often a quote), then anything.
            k = $urandom_range(0, 3);
            push_raw(CH_BACKSLASH);
            push_raw(CH_LOWER_U);
            for (j = 0; j < k; j++)
                push_raw(hex_char(4'($urandom_range(0, 15))));
            if ($urandom_range(0, 2) == 0)
                b = CH_QUOTE;
            else
                do
                    b = 8'($urandom_range(0, 255));
                while (is_hex_char(b));
            push_raw(b);
            for (j = k + 1; j < 4; j++)
                push_raw(8'($urandom_range(0, 255)));
        end
        else
            push_raw(CH_QUOTE);
    endtask

    task automatic report(input string field, input int got, input int want);
        mismatches++;
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", field, got, want, $time);
    endtask

    always @(posedge clk)
        dec_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);

    // Ready and valid settle after the rising edge, so the negative edge sees each transaction.
    always @(negedge clk)
    begin
        if (rst_n && dec_if.valid && dec_if.ready)
        begin
            results_seen++;
            if (dec_if.string_end)
                ends_seen++;
            if (dec_if.bad_escape)
                bad_seen++;
            if (!dec_if.last)
                multi_seen++;
            if (decoded_owed.size() == 0)
                report("unexpected result", int'(dec_if.out_byte), 0);
            else
            begin
                head = decoded_owed.pop_front();
                if (dec_if.out_byte !== head.out_byte)
                    report("out_byte", int'(dec_if.out_byte), int'(head.out_byte));
                if (dec_if.byte_valid !== head.byte_valid)
                    report("byte_valid", int'(dec_if.byte_valid), int'(head.byte_valid));
                if (dec_if.string_end !== head.string_end)
                    report("string_end", int'(dec_if.string_end), int'(head.string_end));
                if (dec_if.bad_escape !== head.bad_escape)
                    report("bad_escape", int'(dec_if.bad_escape), int'(head.bad_escape));
                if (dec_if.last !== head.last)
                    report("last", int'(dec_if.last), int'(head.last));
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int         i;
        int         phase;
        int         quota;

        rst_n          = 1'b0;
        raw_if.valid   = 1'b0;
        raw_if.in_byte = 8'h00;
        esc_mode       = MODE_NORMAL;
        hex_seen       = 2'd0;
        code_pt        = 16'd0;
        prefix_done    = 1'b0;
        got_digit      = 1'b0;
        src_idle_pct   = 38;
        snk_idle_pct   = 87;
        mismatches     = 0;
        bytes_sent     = 0;
        results_seen   = 0;
        ends_seen      = 0;
        bad_seen       = 0;
        multi_seen     = 0;

        script = '{
            '{8'h00,        1'b1, '{8'h00,   1'b1, 1'b0, 1'b0, 1'b1}},
            '{8'hFF,        1'b1, '{8'hFF,   1'b1, 1'b0, 1'b0, 1'b1}},
            '{CH_QUOTE,     1'b1, '{8'h00,   1'b0, 1'b1, 1'b0, 1'b1}},
            '{CH_BACKSLASH, 1'b0, UNTYPED},
            '{CH_LOWER_N,   1'b1, '{CH_LF,   1'b1, 1'b0, 1'b0, 1'b1}},
            '{CH_BACKSLASH, 1'b0, UNTYPED},
            '{CH_LOWER_T,   1'b1, '{CH_TAB,  1'b1, 1'b0, 1'b0, 1'b1}},
            '{CH_BACKSLASH, 1'b0, UNTYPED},
            '{CH_BACKSLASH, 1'b1, '{CH_BACKSLASH, 1'b1, 1'b0, 1'b0, 1'b1}},
            '{CH_BACKSLASH, 1'b0, UNTYPED},
            '{CH_QUOTE,     1'b1, '{CH_QUOTE, 1'b1, 1'b0, 1'b0, 1'b1}},
            '{CH_BACKSLASH, 1'b0, UNTYPED},
            '{8'hFF,        1'b1, '{8'hFF,   1'b1, 1'b0, 1'b0, 1'b1}},
            '{CH_BACKSLASH, 1'b0, UNTYPED},
            '{CH_LOWER_U,   1'b0, UNTYPED},
            '{"F",          1'b0, UNTYPED},
            '{"f",          1'b0, UNTYPED},
            '{"F",          1'b0, UNTYPED},
            '{"f",          1'b0, UNTYPED},
            '{CH_BACKSLASH, 1'b0, UNTYPED},
            '{CH_LOWER_U,   1'b0, UNTYPED},
            '{CH_QUOTE,     1'b0, UNTYPED},
            '{"1",          1'b0, UNTYPED},
            '{"2",          1'b0, UNTYPED},
            '{"3",          1'b1, '{8'h00,   1'b0, 1'b0, 1'b1, 1'b1}}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Typed rows each yield one result; it replaces the predicted one.
        for (i = 0; i < 25; i++)
        begin
            push_raw(script[i].ch);
            if (script[i].typed)
                decoded_owed[decoded_owed.size() - 1] = script[i].want;
        end

        for (phase = 0; phase < 3; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    src_idle_pct = 38;
                    snk_idle_pct = 87;
                end
                1:
                begin
                    src_idle_pct = 87;
                    snk_idle_pct = 38;
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            quota = bytes_sent + 125;
            while (bytes_sent < quota)
                send_token();
        end

        drain();
        repeat (8) @(posedge clk);

        $display("tb: sent %0d string bytes under three idle patterns; checked %0d results",
                 bytes_sent, results_seen);
        $display("tb: %0d string ends, %0d bad escapes, %0d non-final bytes of multi-byte groups",
                 ends_seen, bad_seen, multi_seen);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
